@@ rtl/apsf_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// apsf_pkg
// Shared types and constants of the Annex B parameter-set filter.
// ----------------------------------------------------------------------------
package apsf_pkg;

   localparam int CMD_DEPTH_DEFAULT = 4;

   localparam logic [7:0] BYTE_ZERO = 8'h00;
   localparam logic [7:0] BYTE_ONE  = 8'h01;

   localparam logic [4:0] NAL_IDR = 5'd5;
   localparam logic [4:0] NAL_SPS = 5'd7;
   localparam logic [4:0] NAL_PPS = 5'd8;

   // one classified input byte: zeros, then an optional 01, then an optional data byte
   typedef struct packed {
      logic [2:0] zeros;
      logic       one;
      logic       byt;
      logic [7:0] data;
      logic       done;
      logic       key;
   } cmd_type;

endpackage
`default_nettype wire

@@ rtl/apsf_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// apsf_front
// Start code tracker: classifies each byte into at most one output command.
// ----------------------------------------------------------------------------
module apsf_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire logic [7:0]       data_byte,
   input  wire logic             last_byte,
   output apsf_pkg::cmd_type     cmd,
   output logic                  cmd_push
);
   import apsf_pkg::*;

   logic [1:0] held_ff, held_in;
   logic       expect_ff, expect_in;
   logic       four_ff, four_in;
   logic       in_hdr_ff, in_hdr_in;
   logic       idr_ff, idr_in;
   logic [4:0] nal_code;
   logic       is_zero;
   logic       hdr_new;
   logic       hdr;
   logic       idr_upd;

   always_comb begin
      nal_code = data_byte[4:0];
      is_zero  = (data_byte == BYTE_ZERO);
      hdr_new  = (nal_code == NAL_SPS) || (nal_code == NAL_PPS);
      hdr      = expect_ff ? hdr_new : in_hdr_ff;
      idr_upd  = idr_ff | (expect_ff && (nal_code == NAL_IDR));

      held_in   = held_ff;
      expect_in = expect_ff;
      four_in   = four_ff;
      in_hdr_in = in_hdr_ff;
      idr_in    = idr_upd;

      cmd.zeros = 3'd0;
      cmd.one   = 1'b0;
      cmd.byt   = 1'b0;
      cmd.data  = data_byte;
      cmd.done  = last_byte;
      cmd.key   = idr_upd;

      if (expect_ff) begin
         // nal header byte: emit the start code and the header if sps/pps
         cmd.zeros = hdr_new ? (four_ff ? 3'd3 : 3'd2) : 3'd0;
         cmd.one   = hdr_new;
         cmd.byt   = hdr_new;
         in_hdr_in = hdr_new;
         expect_in = 1'b0;
         four_in   = 1'b0;
         held_in   = is_zero ? 2'd1 : 2'd0;
      end else if (is_zero) begin
         if (held_ff == 2'd3) begin
            // oldest held zero falls out into the unit
            cmd.zeros = hdr ? (last_byte ? 3'd4 : 3'd1) : 3'd0;
         end else begin
            held_in   = held_ff + 2'd1;
            cmd.zeros = (last_byte && hdr) ? ({1'b0, held_ff} + 3'd1) : 3'd0;
         end
      end else if ((data_byte == BYTE_ONE) && (held_ff >= 2'd2)) begin
         expect_in = 1'b1;
         four_in   = (held_ff == 2'd3);
         held_in   = 2'd0;
      end else begin
         cmd.zeros = hdr ? {1'b0, held_ff} : 3'd0;
         cmd.byt   = hdr;
         held_in   = 2'd0;
      end

      if (last_byte) begin
         held_in   = 2'd0;
         expect_in = 1'b0;
         four_in   = 1'b0;
         in_hdr_in = 1'b0;
         idr_in    = 1'b0;
      end

      cmd_push = accept && ((cmd.zeros != 3'd0) || cmd.one || cmd.byt || last_byte);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff   <= 2'd0;
         expect_ff <= 1'b0;
         four_ff   <= 1'b0;
         in_hdr_ff <= 1'b0;
         idr_ff    <= 1'b0;
      end else if (accept) begin
         held_ff   <= held_in;
         expect_ff <= expect_in;
         four_ff   <= four_in;
         in_hdr_ff <= in_hdr_in;
         idr_ff    <= idr_in;
      end
   end

   a_held_clear_after_sc: assert property (@(posedge clock) disable iff (reset)
      expect_ff |-> (held_ff == 2'd0))
      else $error("zeros held while a start code is pending");

endmodule
`default_nettype wire

@@ rtl/apsf_cmd_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// apsf_cmd_fifo
// Short command queue between the classifier and the output expander.
// ----------------------------------------------------------------------------
module apsf_cmd_fifo #(
   parameter int DEPTH = apsf_pkg::CMD_DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire apsf_pkg::cmd_type push_data,
   output logic                   full,
   input  wire logic              pop,
   output apsf_pkg::cmd_type      pop_data,
   output logic                   not_empty
);
   import apsf_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

   cmd_type         mem_ff [DEPTH];
   logic [PW-1:0]   wr_ff, wr_in;
   logic [PW-1:0]   rd_ff, rd_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   always_comb begin
      full      = (count_ff == CW'(DEPTH));
      not_empty = (count_ff != '0);
      do_push   = push && !full;
      do_pop    = pop && not_empty;
      pop_data  = mem_ff[rd_ff];
      wr_in     = do_push ? ((wr_ff == LAST_PTR) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in     = do_pop  ? ((rd_ff == LAST_PTR) ? '0 : rd_ff + 1'b1) : rd_ff;
      count_in  = count_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("command queue overfilled");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("command pushed into a full queue");

endmodule
`default_nettype wire

@@ rtl/apsf_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// apsf_back
// Output expander: turns each command into results, one per cycle while not stalled.
// ----------------------------------------------------------------------------
module apsf_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire apsf_pkg::cmd_type cmd,
   input  wire logic             cmd_avail,
   output logic                  cmd_pop,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output logic [7:0]            rsp_hdr_byte,
   output logic                  rsp_hdr_valid,
   output logic                  rsp_frame_done,
   output logic                  rsp_keyframe
);
   import apsf_pkg::*;

   cmd_type    cur_ff, cur_in;
   logic       cur_valid_ff, cur_valid_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_hv_ff, out_hv_in;
   logic       out_done_ff, out_done_in;
   logic       out_key_ff, out_key_in;
   logic       emit;
   logic       fin;
   logic [7:0] res_byte;
   logic       res_valid;

   always_comb begin
      // pick the next result of the current command
      if (cur_ff.zeros != 3'd0) begin
         res_byte  = BYTE_ZERO;
         res_valid = 1'b1;
         fin       = (cur_ff.zeros == 3'd1) && !cur_ff.one && !cur_ff.byt;
      end else if (cur_ff.one) begin
         res_byte  = BYTE_ONE;
         res_valid = 1'b1;
         fin       = !cur_ff.byt;
      end else if (cur_ff.byt) begin
         res_byte  = cur_ff.data;
         res_valid = 1'b1;
         fin       = 1'b1;
      end else begin
         // end of frame with nothing to give
         res_byte  = BYTE_ZERO;
         res_valid = 1'b0;
         fin       = 1'b1;
      end

      emit    = cur_valid_ff && (!out_valid_ff || rsp_pop);
      cmd_pop = cmd_avail && (!cur_valid_ff || (emit && fin));

      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      if (cmd_pop) begin
         cur_in       = cmd;
         cur_valid_in = 1'b1;
      end else if (emit) begin
         if (fin) begin
            cur_valid_in = 1'b0;
         end else if (cur_ff.zeros != 3'd0) begin
            cur_in.zeros = cur_ff.zeros - 3'd1;
         end else begin
            cur_in.one = 1'b0;
         end
      end

      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_hv_in    = out_hv_ff;
      out_done_in  = out_done_ff;
      out_key_in   = out_key_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_byte_in  = res_byte;
         out_hv_in    = res_valid;
         out_done_in  = cur_ff.done && fin;
         out_key_in   = cur_ff.done && fin && cur_ff.key;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end

      rsp_empty      = !out_valid_ff;
      rsp_hdr_byte   = out_byte_ff;
      rsp_hdr_valid  = out_hv_ff;
      rsp_frame_done = out_done_ff;
      rsp_keyframe   = out_key_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      out_byte_ff <= out_byte_in;
      out_hv_ff   <= out_hv_in;
      out_done_ff <= out_done_in;
      out_key_ff  <= out_key_in;
   end

   a_key_with_done: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_key_ff) |-> out_done_ff)
      else $error("keyframe flag without frame end");

   a_empty_is_final: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_hv_ff) |-> (out_done_ff && (out_byte_ff == BYTE_ZERO)))
      else $error("empty result that does not close a frame");

endmodule
`default_nettype wire

@@ rtl/annexb_param_set_filter.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// annexb_param_set_filter
// Passes through the SPS and PPS units of an H.264 Annex B frame.
// ----------------------------------------------------------------------------
// Input queue port: one stream byte per transfer (req_push while req_full is
// low), req_last_byte marks the final byte of a frame. Result queue port: the
// oldest result sits on the rsp_ ports while rsp_empty is low and leaves with
// rsp_pop. Each result is one byte of an SPS/PPS unit, start code included;
// the last result of a frame has rsp_frame_done set and rsp_keyframe tells
// whether an IDR unit occurred. A frame with nothing to pass gives a single
// result with rsp_hdr_valid low.
// One byte is taken per cycle while req_full is low. The classifier writes at
// most one command per byte into a CMD_DEPTH-entry queue; the expander turns
// each command into one result per cycle while not stalled, so a header byte
// that completes a start code gives up to five results. A byte's first result
// passes the queue, the current command and the output registers. When the
// receiver stalls, results wait in the output register, the queue fills and
// req_full rises. Reset empties both queues and clears the start code tracker.
// ----------------------------------------------------------------------------
module annexb_param_set_filter #(
   parameter int CMD_DEPTH = apsf_pkg::CMD_DEPTH_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_push,
   output logic            req_full,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_last_byte,
   output logic            rsp_empty,
   input  wire logic       rsp_pop,
   output logic [7:0]      rsp_hdr_byte,
   output logic            rsp_hdr_valid,
   output logic            rsp_frame_done,
   output logic            rsp_keyframe
);
   import apsf_pkg::*;

   cmd_type front_cmd;
   cmd_type head_cmd;
   logic    front_push;
   logic    cmd_full;
   logic    cmd_avail;
   logic    cmd_pop;
   logic    accept;

   assign req_full = cmd_full;
   assign accept   = req_push && !cmd_full;

   apsf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_data_byte),
      .last_byte (req_last_byte),
      .cmd       (front_cmd),
      .cmd_push  (front_push)
   );

   apsf_cmd_fifo #(
      .DEPTH (CMD_DEPTH)
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_cmd),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (head_cmd),
      .not_empty (cmd_avail)
   );

   apsf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd            (head_cmd),
      .cmd_avail      (cmd_avail),
      .cmd_pop        (cmd_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_hdr_byte   (rsp_hdr_byte),
      .rsp_hdr_valid  (rsp_hdr_valid),
      .rsp_frame_done (rsp_frame_done),
      .rsp_keyframe   (rsp_keyframe)
   );

endmodule
`default_nettype wire

@@ bench/annexb_param_set_filter_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// annexb_param_set_filter_tb
// Feeds H.264 Annex B frames through the parameter-set filter and compares
// every result with a cycle-free model of the start code tracker. A short
// hand-written set of frames is followed by random frames that are mostly
// well formed, with lead-in junk, noise frames and cut-off frames mixed in.
// ----------------------------------------------------------------------------
module annexb_param_set_filter_tb;
   import apsf_pkg::*;

   localparam logic [4:0] NAL_SLICE   = 5'd1;
   localparam int         STALL_LIMIT = 4000;
   localparam int         DRAIN_CYCLES = 20;

   typedef struct packed {
      logic [7:0] hdr_byte;
      logic       hdr_valid;
      logic       frame_done;
      logic       keyframe;
   } hdr_result_type;

   class header_scoreboard_type;
      hdr_result_type expected_hdr[$];
      logic [7:0]  zero_hist[4];
      int unsigned held;
      int unsigned sc_len;
      int unsigned step_count;
      bit          expect_nal;
      bit          in_param_set;
      bit          idr_seen;
      int unsigned errors;
      int unsigned checked;
      int unsigned bytes_in;
      int unsigned frames;
      int unsigned keyframes;

      function new();
         clear_state();
      endfunction

      function void clear_state();
         foreach (zero_hist[k]) zero_hist[k] = BYTE_ZERO;
         held = 0;
         sc_len = 0;
         expect_nal = 0;
         in_param_set = 0;
         idr_seen = 0;
      endfunction

      function void emit_byte(logic [7:0] v);
         hdr_result_type r;
         r.hdr_byte = v;
         r.hdr_valid = 1'b1;
         r.frame_done = 1'b0;
         r.keyframe = 1'b0;
         expected_hdr.push_back(r);
         step_count++;
      endfunction

      // held zeros turn out not to open a start code
      function void release_zeros();
         for (int k = 0; k < held && k < 4; k++) begin
            if (in_param_set) emit_byte(zero_hist[k]);
         end
         held = 0;
      endfunction

      function void note_byte(logic [7:0] b, logic last);
         logic [4:0]  nal;
         hdr_result_type r;
         step_count = 0;
         bytes_in++;
         if (expect_nal) begin
            nal = b[4:0];
            in_param_set = (nal == NAL_SPS || nal == NAL_PPS);
            if (nal == NAL_IDR) idr_seen = 1;
            if (in_param_set) begin
               for (int k = 0; k < sc_len && k < 4; k++) emit_byte(zero_hist[k]);
               emit_byte(b);
            end
            expect_nal = 0;
            sc_len = 0;
            held = 0;
            // a zero header byte may begin the next start code
            if (b == BYTE_ZERO) begin
               zero_hist[0] = BYTE_ZERO;
               held = 1;
            end
         end else if (b == BYTE_ZERO) begin
            if (held >= 3) begin
               if (in_param_set) emit_byte(zero_hist[0]);
               zero_hist[0] = zero_hist[1];
               zero_hist[1] = zero_hist[2];
               zero_hist[2] = BYTE_ZERO;
               held = 3;
            end else begin
               zero_hist[held] = BYTE_ZERO;
               held++;
            end
         end else if (b == BYTE_ONE && held >= 2) begin
            zero_hist[held & 3] = BYTE_ONE;
            sc_len = held + 1;
            held = sc_len;
            expect_nal = 1;
         end else begin
            release_zeros();
            if (in_param_set) emit_byte(b);
         end

         if (last) begin
            if (expect_nal) held = 0;
            else release_zeros();
            if (step_count == 0) begin
               r = '0;
               expected_hdr.push_back(r);
            end
            r = expected_hdr.pop_back();
            r.frame_done = 1'b1;
            r.keyframe = idr_seen;
            expected_hdr.push_back(r);
            frames++;
            if (idr_seen) keyframes++;
            clear_state();
         end
      endfunction

      function void compare_field(string what, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
         end
      endfunction

      function void check_result(hdr_result_type got);
         hdr_result_type want;
         if (expected_hdr.size() == 0) begin
            errors++;
            $display("%0t: result with nothing expected, actual %h/%b/%b/%b", $time,
                     got.hdr_byte, got.hdr_valid, got.frame_done, got.keyframe);
            return;
         end
         want = expected_hdr.pop_front();
         checked++;
         compare_field("hdr_byte", want.hdr_byte, got.hdr_byte);
         compare_field("hdr_valid", 8'(want.hdr_valid), 8'(got.hdr_valid));
         compare_field("frame_done", 8'(want.frame_done), 8'(got.frame_done));
         compare_field("keyframe", 8'(want.keyframe), 8'(got.keyframe));
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_last_byte = 1'b0;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic [7:0] rsp_hdr_byte;
   logic       rsp_hdr_valid;
   logic       rsp_frame_done;
   logic       rsp_keyframe;

   int unsigned send_gap_pct = 8;
   int unsigned recv_gap_pct = 54;
   int unsigned stall_cycles = 0;
   logic [7:0]  frame_bytes[$];
   header_scoreboard_type sb;

   annexb_param_set_filter uut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_data_byte  (req_data_byte),
      .req_last_byte  (req_last_byte),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_hdr_byte   (rsp_hdr_byte),
      .rsp_hdr_valid  (rsp_hdr_valid),
      .rsp_frame_done (rsp_frame_done),
      .rsp_keyframe   (rsp_keyframe)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // transfer monitor on both sides, plus the receiver's random pop
   always @(posedge clock) begin
      hdr_result_type got;
      if (!reset && req_push && !req_full) sb.note_byte(req_data_byte, req_last_byte);
      if (!reset && rsp_pop && !rsp_empty) begin
         got.hdr_byte = rsp_hdr_byte;
         got.hdr_valid = rsp_hdr_valid;
         got.frame_done = rsp_frame_done;
         got.keyframe = rsp_keyframe;
         sb.check_result(got);
      end
      rsp_pop <= !reset && ($urandom_range(99) >= recv_gap_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("[annexb_param_set_filter] ERROR");
            $finish;
         end
      end
   end

   task automatic send_byte(input logic [7:0] d, input logic l);
      while ($urandom_range(99) < send_gap_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data_byte <= d;
      req_last_byte <= l;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   task automatic send_frame();
      foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
   endtask

   function automatic logic [7:0] payload_byte();
      logic [7:0] v;
      case ($urandom_range(9)) inside
         [0:2]:   v = BYTE_ZERO;
         3:       v = BYTE_ONE;
         default: v = 8'($urandom_range(255));
      endcase
      return v;
   endfunction

   task automatic build_random_frame();
      int unsigned cut;
      logic [4:0]  nal;
      logic [2:0]  nri;
      frame_bytes.delete();
      if ($urandom_range(5) == 0) begin
         // noise frame, zeros and ones frequent enough to form stray start codes
         repeat ($urandom_range(1, 10)) frame_bytes.push_back(payload_byte());
      end else begin
         if ($urandom_range(3) == 0) frame_bytes.push_back(8'($urandom_range(255)));
         repeat ($urandom_range(1, 3)) begin
            repeat ($urandom_range(2, 3)) frame_bytes.push_back(BYTE_ZERO);
            frame_bytes.push_back(BYTE_ONE);
            case ($urandom_range(4))
               0:       nal = NAL_SPS;
               1:       nal = NAL_PPS;
               2:       nal = NAL_IDR;
               3:       nal = NAL_SLICE;
               default: nal = 5'($urandom_range(31));
            endcase
            nri = 3'($urandom_range(7));
            frame_bytes.push_back({nri, nal});
            repeat ($urandom_range(0, 6)) frame_bytes.push_back(payload_byte());
         end
         // cut-off frame: may end inside a start code or right after one
         if ($urandom_range(4) == 0) begin
            cut = $urandom_range(1, frame_bytes.size());
            while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
         end
      end
   endtask

   initial begin
      int phase;
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // 4-byte SPS, PPS with high header bits, zeros held at frame end
      frame_bytes = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h67, 8'hFF,
                      8'h00, 8'h00, 8'h01, 8'hE8, 8'h00, 8'h00};
      send_frame();
      // IDR, long zero run, zero header byte, frame ends after a start code
      frame_bytes = '{8'h00, 8'h00, 8'h01, 8'h65, 8'h00, 8'h00,
                      8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01};
      send_frame();
      // lone junk byte, nothing to pass
      frame_bytes = '{8'hFF};
      send_frame();

      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0:       begin send_gap_pct = 8;  recv_gap_pct = 54; end
            1:       begin send_gap_pct = 54; recv_gap_pct = 8;  end
            default: begin send_gap_pct = 0;  recv_gap_pct = 0;  end
         endcase
         while (sb.bytes_in < 25 + 60 * (phase + 1)) begin
            build_random_frame();
            send_frame();
         end
      end
      req_push <= 1'b0;

      while (sb.expected_hdr.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d frames (%0d with an IDR unit), %0d bytes in", sb.frames,
               sb.keyframes, sb.bytes_in);
      $display("%0d results checked, %0d mismatches", sb.checked, sb.errors);
      if (sb.errors == 0) begin
         $display("[annexb_param_set_filter] OK");
      end else begin
         $display("[annexb_param_set_filter] ERROR");
      end
      $finish;
   end

endmodule
